[src/bcd_adjust_unit_core_macros.svh]
// ----------------------------------------------------------------------------
// bcd adjust unit assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BCD_ADJUST_UNIT_CORE_MACROS_SVH
`define BCD_ADJUST_UNIT_CORE_MACROS_SVH

// same-cycle implication, disabled while rst is high
`define BAU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define BAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bau_pkg.sv]
// ----------------------------------------------------------------------------
// bcd adjust unit package
// opcodes, pipeline item type and widths shared by the unit's modules
// ----------------------------------------------------------------------------
package bau_pkg;

   // number of restoring divide cells, one per quotient bit
   localparam int DIV_STEPS = 8;

   // instruction selector codes
   typedef enum logic [2:0] {
      OP_AAA = 3'd0,
      OP_AAS = 3'd1,
      OP_DAA = 3'd2,
      OP_DAS = 3'd3,
      OP_AAD = 3'd4,
      OP_AAM = 3'd5
   } op_type;

   // adjust constants
   localparam logic [3:0] NIBBLE_MAX     = 4'd9;
   localparam logic [7:0] LOW_ADJ        = 8'h06;
   localparam logic [7:0] HIGH_ADJ       = 8'h60;
   localparam logic [7:0] BCD_MAX        = 8'h99;

   // item carried through the divide chain
   typedef struct packed {
      logic [7:0] al;
      logic [7:0] ah;
      logic [7:0] divisor;
      logic       cf;
      logic       af;
      logic       sf;
      logic       zf;
      logic       pf;
      logic       szp;
      logic       de;
      logic       is_div;
      logic [7:0] rem;
      logic [7:0] dq;
   } item_type;

endpackage

[src/bau_front.sv]
// ----------------------------------------------------------------------------
// bcd adjust front stage
// executes the adjust and aad instructions and seeds the aam divide
// ----------------------------------------------------------------------------
module bau_front
   import bau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [2:0] op,
   input  logic [7:0] al_in,
   input  logic [7:0] ah_in,
   input  logic [7:0] imm,
   input  logic       cf_in,
   input  logic       af_in,
   input  logic       sf_in,
   input  logic       zf_in,
   input  logic       pf_in,
   output logic       out_valid,
   output item_type   out_item,
   input  logic       out_ready
);

   logic       valid_ff, valid_in;
   item_type   item_ff, item_in;
   logic       low_fix, high_fix;
   logic       load;
   logic [15:0] prod;
   logic [7:0] al_low;

   // handshake for this stage
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // decimal adjust decisions
   assign low_fix  = (al_in[3:0] > NIBBLE_MAX) || af_in;
   assign high_fix = (al_in > BCD_MAX) || cf_in;
   assign prod     = ah_in * imm;
   assign al_low   = low_fix ? (al_in + LOW_ADJ) : al_in;

   // instruction execute
   always_comb begin
      logic [7:0] al_step;
      item_in         = '0;
      al_step         = al_in;
      item_in.al      = al_in;
      item_in.ah      = ah_in;
      item_in.divisor = imm;
      item_in.cf      = cf_in;
      item_in.af      = af_in;
      item_in.sf      = sf_in;
      item_in.zf      = zf_in;
      item_in.pf      = pf_in;
      item_in.rem     = '0;
      item_in.dq      = al_in;
      unique case (op_type'(op))
         OP_AAA: begin
            item_in.al = {4'h0, al_low[3:0]};
            item_in.ah = low_fix ? (ah_in + 8'd1) : ah_in;
            item_in.af = low_fix;
            item_in.cf = low_fix;
         end
         OP_AAS: begin
            al_step    = al_in - LOW_ADJ;
            item_in.al = low_fix ? {4'h0, al_step[3:0]} : {4'h0, al_in[3:0]};
            item_in.ah = low_fix ? (ah_in - 8'd1) : ah_in;
            item_in.af = low_fix;
            item_in.cf = low_fix;
         end
         OP_DAA: begin
            item_in.al  = high_fix ? (al_low + HIGH_ADJ) : al_low;
            item_in.af  = low_fix;
            item_in.cf  = high_fix;
            item_in.szp = 1'b1;
         end
         OP_DAS: begin
            al_step     = low_fix ? (al_in - LOW_ADJ) : al_in;
            item_in.al  = high_fix ? (al_step - HIGH_ADJ) : al_step;
            item_in.af  = low_fix;
            item_in.cf  = high_fix || (low_fix && (cf_in || (al_in < LOW_ADJ)));
            item_in.szp = 1'b1;
         end
         OP_AAD: begin
            item_in.al  = al_in + prod[7:0];
            item_in.ah  = 8'h00;
            item_in.szp = 1'b1;
         end
         OP_AAM: begin
            item_in.de     = (imm == 8'h00);
            item_in.is_div = (imm != 8'h00);
            item_in.szp    = (imm != 8'h00);
         end
         default: begin
         end
      endcase
   end

   // stage valid
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[src/bau_div_cell.sv]
// ----------------------------------------------------------------------------
// bcd adjust divide cell
// one restoring division step: shifts in a dividend bit, emits a quotient bit
// ----------------------------------------------------------------------------
module bau_div_cell
   import bau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   output item_type out_item,
   input  logic     out_ready
);

   logic       valid_ff, valid_in;
   item_type   item_ff, item_in;
   logic       load;
   logic [8:0] rem_shift;
   logic [8:0] rem_diff;
   logic       q_bit;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // trial subtract of the divisor from the shifted remainder
   assign rem_shift = {in_item.rem, in_item.dq[7]};
   assign rem_diff  = rem_shift - {1'b0, in_item.divisor};
   assign q_bit     = (rem_shift >= {1'b0, in_item.divisor});

   always_comb begin
      item_in     = in_item;
      item_in.rem = q_bit ? rem_diff[7:0] : rem_shift[7:0];
      item_in.dq  = {in_item.dq[6:0], q_bit};
   end

   // cell valid
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[src/bau_back.sv]
// ----------------------------------------------------------------------------
// bcd adjust back stage
// picks the aam quotient and remainder, sets sign, zero and parity, holds result
// ----------------------------------------------------------------------------
module bau_back
   import bau_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output logic [7:0] al_out,
   output logic [7:0] ah_out,
   output logic     cf_out,
   output logic     af_out,
   output logic     sf_out,
   output logic     zf_out,
   output logic     pf_out,
   output logic     divide_error
);

   logic       valid_ff, valid_in;
   logic       load;
   logic [7:0] al_res, ah_res;
   logic       sf_res, zf_res, pf_res;
   logic [7:0] al_ff, ah_ff;
   logic       cf_ff, af_ff, sf_ff, zf_ff, pf_ff, de_ff;

   assign in_ready = !valid_ff || rsp_ready;
   assign load     = in_valid && in_ready;

   // aam takes remainder into al and quotient into ah
   assign al_res = in_item.is_div ? in_item.rem : in_item.al;
   assign ah_res = in_item.is_div ? in_item.dq  : in_item.ah;

   // result flags from al where written
   assign sf_res = in_item.szp ? al_res[7]          : in_item.sf;
   assign zf_res = in_item.szp ? (al_res == 8'h00)  : in_item.zf;
   assign pf_res = in_item.szp ? ~(^al_res)         : in_item.pf;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load) begin
         al_ff <= al_res;
         ah_ff <= ah_res;
         cf_ff <= in_item.cf;
         af_ff <= in_item.af;
         sf_ff <= sf_res;
         zf_ff <= zf_res;
         pf_ff <= pf_res;
         de_ff <= in_item.de;
      end
   end

   assign rsp_valid    = valid_ff;
   assign al_out       = al_ff;
   assign ah_out       = ah_ff;
   assign cf_out       = cf_ff;
   assign af_out       = af_ff;
   assign sf_out       = sf_ff;
   assign zf_out       = zf_ff;
   assign pf_out       = pf_ff;
   assign divide_error = de_ff;

endmodule

[src/bcd_adjust_unit_core.sv]
// ----------------------------------------------------------------------------
// bcd adjust unit core
// x86 aaa, aas, daa, das, aad and aam execute unit on stream channels
// path from request transfer to rsp_tvalid: front, 8 divide cells, output register
// throughput: one instruction per cycle while rsp_tready is high; every stage can hold one item
// the aam divide is a row of 8 restoring cells, one quotient bit per cell
// reset clears all stage valid bits; no result is pending after reset
// ----------------------------------------------------------------------------
module bcd_adjust_unit_core
   import bau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // al [7:0], ah [15:8], imm [23:16], cf [24], af [25], sf [26], zf [27], pf [28]
   input  logic [31:0] req_tdata,
   // op [2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // al [7:0], ah [15:8], cf [16], af [17], sf [18], zf [19], pf [20]
   output logic [23:0] rsp_tdata,
   // divide_error [0]
   output logic        rsp_tuser
);

   logic       chain_valid [0:DIV_STEPS];
   logic       chain_ready [0:DIV_STEPS];
   item_type   chain_item  [0:DIV_STEPS];
   logic [7:0] al_out, ah_out;
   logic       cf_out, af_out, sf_out, zf_out, pf_out, divide_error;

   // instruction execute and divide seed
   bau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .op        (req_tuser),
      .al_in     (req_tdata[7:0]),
      .ah_in     (req_tdata[15:8]),
      .imm       (req_tdata[23:16]),
      .cf_in     (req_tdata[24]),
      .af_in     (req_tdata[25]),
      .sf_in     (req_tdata[26]),
      .zf_in     (req_tdata[27]),
      .pf_in     (req_tdata[28]),
      .out_valid (chain_valid[0]),
      .out_item  (chain_item[0]),
      .out_ready (chain_ready[0])
   );

   // row of divide cells
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
      bau_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_item   (chain_item[k]),
         .out_valid (chain_valid[k+1]),
         .out_item  (chain_item[k+1]),
         .out_ready (chain_ready[k+1])
      );
   end

   // flags and result register
   bau_back u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[DIV_STEPS]),
      .in_ready     (chain_ready[DIV_STEPS]),
      .in_item      (chain_item[DIV_STEPS]),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .al_out       (al_out),
      .ah_out       (ah_out),
      .cf_out       (cf_out),
      .af_out       (af_out),
      .sf_out       (sf_out),
      .zf_out       (zf_out),
      .pf_out       (pf_out),
      .divide_error (divide_error)
   );

   assign rsp_tdata = {3'b000, pf_out, zf_out, sf_out, af_out, cf_out, ah_out, al_out};
   assign rsp_tuser = divide_error;

endmodule

[src/bau_checker.sv]
// ----------------------------------------------------------------------------
// bcd adjust unit port checker
// watches the stream ports of the core for stall, reset and pad-bit behavior
// ----------------------------------------------------------------------------
`include "bcd_adjust_unit_core_macros.svh"

module bau_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled result keeps its payload
   `BAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // with the output side free, every stage can move, so a request is taken
   `BAU_ASSERT_SAME(a_req_ready, clock, reset, !rsp_tvalid || rsp_tready, req_tready, "request not taken while output side is free")

   // reset leaves no result pending
   `BAU_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid, "result pending after reset")

   // pad bits of the result stay zero
   `BAU_ASSERT_SAME(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[23:21] == 3'b000, "result pad bits set")

endmodule

bind bcd_adjust_unit_core bau_checker u_bau_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[bench/bcd_adjust_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd adjust unit checker
// watches both stream channels of the unit, works out the expected
// adjust result of every request transfer and compares it field by field
// with the response transfers in order
// ----------------------------------------------------------------------------
module bcd_adjust_unit_checker
   import bau_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // al [7:0], ah [15:8], imm [23:16], cf [24], af [25], sf [26], zf [27], pf [28]
   input  logic [31:0] req_tdata,
   // op [2:0]
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // al [7:0], ah [15:8], cf [16], af [17], sf [18], zf [19], pf [20]
   input  logic [23:0] rsp_tdata,
   // divide_error [0]
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          pending_count
);

   localparam logic [7:0] LOW_NIBBLE_MASK = 8'h0f;
   localparam logic [7:0] DAA_CARRY_FROM  = 8'hfa;

   typedef struct packed {
      logic [7:0] al;
      logic [7:0] ah;
      logic       cf;
      logic       af;
      logic       sf;
      logic       zf;
      logic       pf;
      logic       de;
   } adjust_result_type;

   adjust_result_type adjust_results_q[$];
   int fails   = 0;
   int waiting = 0;

   assign fail_count    = fails;
   assign pending_count = waiting;

   // decimal adjust of one instruction, as the unit must execute it
   function automatic adjust_result_type predict_adjust(input logic [2:0] op,
                                                        input logic [31:0] d);
      adjust_result_type r;
      logic [7:0] al, ah, imm, old_al;
      logic       cf, af, sf, zf, pf, de, szp, old_cf, low_fix;
      al      = d[7:0];
      ah      = d[15:8];
      imm     = d[23:16];
      cf      = d[24];
      af      = d[25];
      sf      = d[26];
      zf      = d[27];
      pf      = d[28];
      de      = 1'b0;
      szp     = 1'b0;
      old_al  = al;
      old_cf  = cf;
      low_fix = (al[3:0] > NIBBLE_MAX) || af;
      case (op)
         OP_AAA: begin
            if (low_fix) begin
               al = (al + LOW_ADJ) & LOW_NIBBLE_MASK;
               ah = ah + 8'd1;
               af = 1'b1;
               cf = 1'b1;
            end else begin
               al = al & LOW_NIBBLE_MASK;
               af = 1'b0;
               cf = 1'b0;
            end
         end
         OP_AAS: begin
            if (low_fix) begin
               al = (al - LOW_ADJ) & LOW_NIBBLE_MASK;
               ah = ah - 8'd1;
               af = 1'b1;
               cf = 1'b1;
            end else begin
               al = al & LOW_NIBBLE_MASK;
               af = 1'b0;
               cf = 1'b0;
            end
         end
         OP_DAA: begin
            cf = 1'b0;
            if (low_fix) begin
               al = al + LOW_ADJ;
               if (old_cf || old_al >= DAA_CARRY_FROM) cf = 1'b1;
               af = 1'b1;
            end else begin
               af = 1'b0;
            end
            // the high correction decides the final carry on its own
            if (old_al > BCD_MAX || old_cf) begin
               al = al + HIGH_ADJ;
               cf = 1'b1;
            end else begin
               cf = 1'b0;
            end
            szp = 1'b1;
         end
         OP_DAS: begin
            cf = 1'b0;
            if (low_fix) begin
               al = al - LOW_ADJ;
               if (old_cf || old_al < LOW_ADJ) cf = 1'b1;
               af = 1'b1;
            end else begin
               af = 1'b0;
            end
            // borrow from the low step survives when no high step follows
            if (old_al > BCD_MAX || old_cf) begin
               al = al - HIGH_ADJ;
               cf = 1'b1;
            end
            szp = 1'b1;
         end
         OP_AAD: begin
            al  = al + ah * imm;
            ah  = 8'd0;
            szp = 1'b1;
         end
         OP_AAM: begin
            // zero base: divide error, nothing written
            if (imm == 8'd0) begin
               de = 1'b1;
            end else begin
               ah  = al / imm;
               al  = al % imm;
               szp = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (szp) begin
         sf = al[7];
         zf = (al == 8'd0);
         pf = ~^al;
      end
      r.al = al;
      r.ah = ah;
      r.cf = cf;
      r.af = af;
      r.sf = sf;
      r.zf = zf;
      r.pf = pf;
      r.de = de;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fails++;
      end
   endtask

   // compare response transfers first, then queue the new request
   always @(posedge clock) begin
      adjust_result_type got;
      adjust_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.al = rsp_tdata[7:0];
            got.ah = rsp_tdata[15:8];
            got.cf = rsp_tdata[16];
            got.af = rsp_tdata[17];
            got.sf = rsp_tdata[18];
            got.zf = rsp_tdata[19];
            got.pf = rsp_tdata[20];
            got.de = rsp_tuser;
            if (adjust_results_q.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, actual %0h", $time, got);
               fails++;
            end else begin
               want = adjust_results_q.pop_front();
               check_field("al", want.al, got.al);
               check_field("ah", want.ah, got.ah);
               check_field("cf", want.cf, got.cf);
               check_field("af", want.af, got.af);
               check_field("sf", want.sf, got.sf);
               check_field("zf", want.zf, got.zf);
               check_field("pf", want.pf, got.pf);
               check_field("divide_error", want.de, got.de);
            end
         end
         if (req_tvalid && req_tready)
            adjust_results_q.push_back(predict_adjust(req_tuser, req_tdata));
      end
      waiting = adjust_results_q.size();
   end

endmodule

[bench/tb_bcd_adjust_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd adjust unit testbench
// drives directed and random decimal adjust instructions into the unit
// with random gaps and response back-pressure, one long hold-off included;
// the checker predicts and compares every response
// ----------------------------------------------------------------------------
module tb_bcd_adjust_unit_core;
   import bau_pkg::*;

   localparam logic [2:0] OP_SPARE_LO  = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;
   localparam int         RANDOM_ITEMS = 1300;
   localparam int         TAIL_ITEMS   = 150;
   localparam int         HOLD_CYCLES  = 200;
   localparam int         HOLD_START   = 400;
   localparam int         DRAIN_CYCLES = 20;
   localparam int         CYCLE_LIMIT  = 200000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   int          fail_count;
   int          pending_count;
   logic        tail_phase;

   bcd_adjust_unit_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   bcd_adjust_unit_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // flags are given as {pf, zf, sf, af, cf}
   function automatic logic [31:0] pack_req(input logic [7:0] al, input logic [7:0] ah,
                                            input logic [7:0] imm, input logic [4:0] flags);
      return {3'b000, flags, imm, ah, al};
   endfunction

   // offer one item from a falling edge and hold it until the transfer
   task automatic send_item(input logic [2:0] op, input logic [31:0] d);
      req_tuser  <= op;
      req_tdata  <= d;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_req(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Regression FAIL");
      $finish;
   end

   // response side: random stalls, one long hold-off, none in the tail
   initial begin
      int cyc;
      int n;
      bit hold_done;
      cyc = 0;
      hold_done = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      while (!tail_phase) begin
         if (!hold_done && cyc >= HOLD_START) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            cyc += HOLD_CYCLES;
            hold_done = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(20, 60);
            rsp_tready <= 1'b1;
            repeat (n) @(negedge clock);
            cyc += n;
         end else if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
            cyc += n;
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
            cyc++;
         end
      end
      rsp_tready <= 1'b1;
   end

   // request side: reset, directed items, random items, drain, verdict
   initial begin
      logic [2:0]  op;
      logic [7:0]  al, ah, imm;
      logic [4:0]  flags;
      int          sel;
      bit          quiet_block;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_AAA;
      tail_phase = 1'b0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: field extremes, every opcode, divide error, spare codes
      send_item(OP_AAA, pack_req(8'hff, 8'hff, 8'h00, 5'b00000));
      send_item(OP_AAA, pack_req(8'h09, 8'h12, 8'h00, 5'b11100));
      send_item(OP_AAA, pack_req(8'h00, 8'h00, 8'hff, 5'b00010));
      send_item(OP_AAS, pack_req(8'h00, 8'h00, 8'h00, 5'b00010));
      send_item(OP_AAS, pack_req(8'h0a, 8'h80, 8'h00, 5'b00001));
      send_item(OP_AAS, pack_req(8'hff, 8'hff, 8'hff, 5'b11111));
      send_item(OP_DAA, pack_req(8'h99, 8'h00, 8'h00, 5'b00000));
      send_item(OP_DAA, pack_req(8'h9a, 8'h00, 8'h00, 5'b00000));
      send_item(OP_DAA, pack_req(8'hfa, 8'h55, 8'h00, 5'b11100));
      send_item(OP_DAA, pack_req(8'h00, 8'h00, 8'h00, 5'b00011));
      send_item(OP_DAA, pack_req(8'hff, 8'hff, 8'hff, 5'b11111));
      send_item(OP_DAS, pack_req(8'h05, 8'h00, 8'h00, 5'b00010));
      send_item(OP_DAS, pack_req(8'h00, 8'h00, 8'h00, 5'b00001));
      send_item(OP_DAS, pack_req(8'h9a, 8'haa, 8'h00, 5'b00000));
      send_item(OP_DAS, pack_req(8'hff, 8'hff, 8'hff, 5'b00011));
      send_item(OP_AAD, pack_req(8'hff, 8'hff, 8'hff, 5'b00000));
      send_item(OP_AAD, pack_req(8'h00, 8'h00, 8'h00, 5'b11111));
      send_item(OP_AAD, pack_req(8'h09, 8'h09, 8'h0a, 5'b00011));
      send_item(OP_AAM, pack_req(8'hff, 8'h3c, 8'h00, 5'b11111));
      send_item(OP_AAM, pack_req(8'h00, 8'hff, 8'h00, 5'b00000));
      send_item(OP_AAM, pack_req(8'hff, 8'h00, 8'h01, 5'b00011));
      send_item(OP_AAM, pack_req(8'h63, 8'h00, 8'h0a, 5'b11100));
      send_item(OP_AAM, pack_req(8'hff, 8'hff, 8'hff, 5'b00000));
      send_item(OP_SPARE_LO, pack_req(8'ha5, 8'h5a, 8'h3c, 5'b10101));
      send_item(OP_SPARE_HI, pack_req(8'hff, 8'hff, 8'hff, 5'b11111));

      // random items, biased toward the adjust boundaries
      quiet_block = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) quiet_block = ($urandom_range(0, 3) == 0);
         if (i == RANDOM_ITEMS - TAIL_ITEMS) tail_phase = 1'b1;
         sel = $urandom_range(0, 15);
         if (sel < 14) op = 3'(sel % 6);
         else op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
         ah = 8'($urandom);
         flags = 5'($urandom);
         case ($urandom_range(0, 5))
            0: al = {4'($urandom), 4'd9};
            1: al = {4'($urandom), 4'd10};
            2: al = 8'($urandom_range(8'h96, 8'h9b));
            3: al = 8'($urandom_range(8'hf8, 8'hff));
            4: al = 8'($urandom_range(8'h00, 8'h07));
            default: al = 8'($urandom);
         endcase
         case ($urandom_range(0, 7))
            0: imm = 8'h00;
            1, 2: imm = 8'd10;
            3: imm = 8'($urandom_range(1, 16));
            default: imm = 8'($urandom);
         endcase
         send_item(op, pack_req(al, ah, imm, flags));
         if (!tail_phase && !quiet_block && $urandom_range(0, 3) == 0)
            idle_req($urandom_range(1, 13));
      end
      req_tvalid <= 1'b0;

      // drain, then a few cycles more for stray responses
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/bau_pkg.sv
src/bau_front.sv
src/bau_div_cell.sv
src/bau_back.sv
src/bcd_adjust_unit_core.sv
src/bau_checker.sv
bench/bcd_adjust_unit_checker.sv
bench/tb_bcd_adjust_unit_core.sv
